// ===== hdl/multi_key_press_duration_classifier_defines.svh =====
// Assertion macros shared by the key press classifier sources.
// Depends on nothing; included by the files that write assertions.
`ifndef MULTI_KEY_PRESS_DURATION_CLASSIFIER_DEFINES_SVH
`define MULTI_KEY_PRESS_DURATION_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define MKPD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mkpd: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define MKPD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mkpd: next-cycle check failed");

`endif

// ===== hdl/mkpd_pkg.sv =====
// Shared constants and types for the key press duration classifier.
// Depends on nothing; used by mkpd_slot_ram and the top level.
`timescale 1ns / 1ps

package mkpd_pkg;

    localparam int KEY_SLOTS   = 16;
    localparam int MAX_RESULTS = 16;

    localparam int OP_W   = 2;
    localparam int KEY_W  = 16;
    localparam int TIME_W = 32;
    localparam int KIND_W = 2;
    localparam int CFG_W  = 16;
    localparam int CFG_AW = 2;

    localparam logic [OP_W-1:0] OP_PRESS   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_CANCEL  = 2'd2;
    localparam logic [OP_W-1:0] OP_TICK    = 2'd3;

    localparam logic [KIND_W-1:0] EVT_SHORT = 2'd0;
    localparam logic [KIND_W-1:0] EVT_LONG  = 2'd1;
    localparam logic [KIND_W-1:0] EVT_DROP  = 2'd2;

    localparam logic [CFG_AW-1:0] CFG_SHORT_MIN = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_LONG      = 2'd1;

    localparam logic [CFG_W-1:0] SHORT_MIN_RST = 16'd20;
    localparam logic [CFG_W-1:0] LONG_RST      = 16'd1000;

    // Write request into the slot memories.
    typedef struct packed {
        logic              key_we;
        logic              time_we;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] press_time;
    } t_slot_wr;

endpackage

// ===== hdl/mkpd_slot_ram.sv =====
// Slot memories: key code and press time per slot, one write and one read port.
// Depends on mkpd_pkg for field widths and the write request type.
`timescale 1ns / 1ps

module mkpd_slot_ram #(
    parameter int KEY_SLOTS = mkpd_pkg::KEY_SLOTS,
    parameter int AW        = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1
) (
    input  logic                        i_clk,
    input  mkpd_pkg::t_slot_wr          i_wr,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic                        i_rd_en,
    input  logic [AW-1:0]               i_rd_addr,
    output logic [mkpd_pkg::KEY_W-1:0]  o_rd_key,
    output logic [mkpd_pkg::TIME_W-1:0] o_rd_time
);

    logic [mkpd_pkg::KEY_W-1:0]  r_key_mem  [KEY_SLOTS];
    logic [mkpd_pkg::TIME_W-1:0] r_time_mem [KEY_SLOTS];
    logic [mkpd_pkg::KEY_W-1:0]  r_rd_key;
    logic [mkpd_pkg::TIME_W-1:0] r_rd_time;

    always_ff @(posedge i_clk) begin
        if (i_wr.key_we) begin
            r_key_mem[i_wr_addr] <= i_wr.key;
        end
        if (i_wr.time_we) begin
            r_time_mem[i_wr_addr] <= i_wr.press_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_key  <= r_key_mem[i_rd_addr];
            r_rd_time <= r_time_mem[i_rd_addr];
        end
    end

    assign o_rd_key  = r_rd_key;
    assign o_rd_time = r_rd_time;

endmodule

// ===== hdl/multi_key_press_duration_classifier.sv =====
// Top level of the key press duration classifier: control, slot scan and results.
// Depends on mkpd_pkg, mkpd_slot_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "multi_key_press_duration_classifier_defines.svh"

// Usage
//   Input: drive i_operation, i_key_code and i_time_ms with start high; the item
//   transfers at the edge where start is high and busy is low. Busy stays high
//   until the item is fully handled.
//   Config: i_cfg_we writes i_cfg_data to register i_cfg_idx (0 short minimum,
//   1 long time) at the clock edge; other indexes are ignored. Write while idle.
//   Results: o_result_strobe marks each result for exactly one cycle; the
//   receiver must take it then, there is no back-pressure.
//   Scan: every pass reads the slot memory one slot a cycle through its single
//   read port. Press, release and cancel run one pass; their result, if any,
//   strobes in the cycle busy falls. A tick runs one pass per long press found
//   plus one final pass, each pass picking the lowest expired key, and stops
//   without the final pass once the result cap is reached. Results of a tick
//   strobe at the end of passes, ascending key.
//   Reset: synchronous, active low; empties the slot table and restores the
//   register defaults (20 and 1000 ms). No clearing pass is needed.
module multi_key_press_duration_classifier #(
    parameter int KEY_SLOTS = mkpd_pkg::KEY_SLOTS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [mkpd_pkg::OP_W-1:0]    i_operation,
    input  logic [mkpd_pkg::KEY_W-1:0]   i_key_code,
    input  logic [mkpd_pkg::TIME_W-1:0]  i_time_ms,
    input  logic                         i_cfg_we,
    input  logic [mkpd_pkg::CFG_AW-1:0]  i_cfg_idx,
    input  logic [mkpd_pkg::CFG_W-1:0]   i_cfg_data,
    output logic                         o_result_strobe,
    output logic [mkpd_pkg::KIND_W-1:0]  o_event_kind,
    output logic [mkpd_pkg::KEY_W-1:0]   o_event_key,
    output logic [mkpd_pkg::TIME_W-1:0]  o_held_ms,
    output logic                         o_last_event
);

    localparam int AW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int CW = $clog2(mkpd_pkg::MAX_RESULTS + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(KEY_SLOTS - 1);
    localparam logic [CW-1:0] CNT_LAST  = CW'(mkpd_pkg::MAX_RESULTS - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_LAST  = 3'd2;
    localparam logic [2:0] ST_DONE  = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    logic [2:0]                    r_state;
    logic [mkpd_pkg::CFG_W-1:0]    r_short_min;
    logic [mkpd_pkg::CFG_W-1:0]    r_long;
    logic [KEY_SLOTS-1:0]          r_used;

    logic [mkpd_pkg::OP_W-1:0]     r_op;
    logic [mkpd_pkg::KEY_W-1:0]    r_key;
    logic [mkpd_pkg::TIME_W-1:0]   r_now;

    logic [AW-1:0]                 r_issue;
    logic                          r_rd_vld;
    logic [AW-1:0]                 r_rd_idx;

    logic                          r_hit;
    logic [AW-1:0]                 r_hit_idx;
    logic [mkpd_pkg::KEY_W-1:0]    r_hit_key;
    logic [mkpd_pkg::TIME_W-1:0]   r_hit_held;
    logic                          r_free_vld;
    logic [AW-1:0]                 r_free_idx;

    logic                          r_pend;
    logic [mkpd_pkg::KEY_W-1:0]    r_pend_key;
    logic [mkpd_pkg::TIME_W-1:0]   r_pend_held;
    logic [CW-1:0]                 r_ecnt;

    logic                          r_out_strobe;
    logic [mkpd_pkg::KIND_W-1:0]   r_out_kind;
    logic [mkpd_pkg::KEY_W-1:0]    r_out_key;
    logic [mkpd_pkg::TIME_W-1:0]   r_out_held;
    logic                          r_out_last;

    mkpd_pkg::t_slot_wr            wr_req;
    logic [AW-1:0]                 wr_addr;
    logic                          rd_en;
    logic [mkpd_pkg::KEY_W-1:0]    rd_key;
    logic [mkpd_pkg::TIME_W-1:0]   rd_time;

    logic                          accept;
    logic                          rd_used;
    logic [mkpd_pkg::TIME_W-1:0]   rd_held;
    logic                          rd_match;
    logic                          rd_due;
    logic                          rd_better;
    logic                          in_done;

    assign accept  = start && (r_state == ST_IDLE);
    assign busy    = (r_state != ST_IDLE);
    assign rd_en   = (r_state == ST_SCAN);
    assign in_done = (r_state == ST_DONE);

    // Per-slot checks on the data returned for the slot read last cycle.
    assign rd_used   = r_used[r_rd_idx];
    assign rd_held   = r_now - rd_time;
    assign rd_match  = rd_used && (rd_key == r_key);
    assign rd_due    = rd_used &&
                       (rd_held >= {{(mkpd_pkg::TIME_W - mkpd_pkg::CFG_W){1'b0}}, r_long});
    assign rd_better = !r_hit || (rd_key < r_hit_key);

    always_comb begin
        wr_req.key_we     = in_done && (r_op == mkpd_pkg::OP_PRESS) && !r_hit && r_free_vld;
        wr_req.time_we    = in_done && (r_op == mkpd_pkg::OP_PRESS) && (r_hit || r_free_vld);
        wr_req.key        = r_key;
        wr_req.press_time = r_now;
        wr_addr           = r_hit ? r_hit_idx : r_free_idx;
    end

    mkpd_slot_ram #(
        .KEY_SLOTS (KEY_SLOTS),
        .AW        (AW)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr      (wr_req),
        .i_wr_addr (wr_addr),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_issue),
        .o_rd_key  (rd_key),
        .o_rd_time (rd_time)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_min <= mkpd_pkg::SHORT_MIN_RST;
            r_long      <= mkpd_pkg::LONG_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mkpd_pkg::CFG_SHORT_MIN: r_short_min <= i_cfg_data;
                mkpd_pkg::CFG_LONG:      r_long      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_issue;
        if (accept) begin
            r_op  <= i_operation;
            r_key <= i_key_code;
            r_now <= i_time_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_used       <= '0;
            r_issue      <= '0;
            r_rd_vld     <= 1'b0;
            r_hit        <= 1'b0;
            r_free_vld   <= 1'b0;
            r_pend       <= 1'b0;
            r_ecnt       <= '0;
            r_out_strobe <= 1'b0;
        end else begin
            r_out_strobe <= 1'b0;
            r_rd_vld     <= rd_en;

            if (r_rd_vld) begin
                if (r_op == mkpd_pkg::OP_TICK) begin
                    // Keep the lowest expired key of this pass.
                    if (rd_due && rd_better) begin
                        r_hit      <= 1'b1;
                        r_hit_idx  <= r_rd_idx;
                        r_hit_key  <= rd_key;
                        r_hit_held <= rd_held;
                    end
                end else begin
                    if (rd_match) begin
                        r_hit      <= 1'b1;
                        r_hit_idx  <= r_rd_idx;
                        r_hit_held <= rd_held;
                    end
                    // Lowest free slot: the first one seen in ascending order.
                    if (!rd_used && !r_free_vld) begin
                        r_free_vld <= 1'b1;
                        r_free_idx <= r_rd_idx;
                    end
                end
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_issue    <= '0;
                        r_hit      <= 1'b0;
                        r_free_vld <= 1'b0;
                        r_pend     <= 1'b0;
                        r_ecnt     <= '0;
                        r_state    <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (r_issue == LAST_SLOT) begin
                        r_state <= ST_LAST;
                    end else begin
                        r_issue <= r_issue + AW'(1);
                    end
                end
                ST_LAST: begin
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    r_state <= ST_IDLE;
                    case (r_op) inside
                        mkpd_pkg::OP_PRESS: begin
                            if (!r_hit && r_free_vld) begin
                                r_used[r_free_idx] <= 1'b1;
                            end else if (!r_hit) begin
                                r_out_strobe <= 1'b1;
                                r_out_kind   <= mkpd_pkg::EVT_DROP;
                                r_out_key    <= r_key;
                                r_out_held   <= '0;
                                r_out_last   <= 1'b1;
                            end
                        end
                        mkpd_pkg::OP_RELEASE, mkpd_pkg::OP_CANCEL: begin
                            if (r_hit) begin
                                r_used[r_hit_idx] <= 1'b0;
                                if ((r_op == mkpd_pkg::OP_RELEASE) && (r_hit_held >
                                    {{(mkpd_pkg::TIME_W - mkpd_pkg::CFG_W){1'b0}},
                                     r_short_min})) begin
                                    r_out_strobe <= 1'b1;
                                    r_out_kind   <= mkpd_pkg::EVT_SHORT;
                                    r_out_key    <= r_key;
                                    r_out_held   <= r_hit_held;
                                    r_out_last   <= 1'b1;
                                end
                            end
                        end
                        default: begin
                            // Tick: deliver the previous find, hold this one back
                            // until it is known whether another follows.
                            if (r_pend) begin
                                r_out_strobe <= 1'b1;
                                r_out_kind   <= mkpd_pkg::EVT_LONG;
                                r_out_key    <= r_pend_key;
                                r_out_held   <= r_pend_held;
                                r_out_last   <= !r_hit;
                            end
                            if (r_hit) begin
                                r_used[r_hit_idx] <= 1'b0;
                                r_pend            <= 1'b1;
                                r_pend_key        <= r_hit_key;
                                r_pend_held       <= r_hit_held;
                                r_ecnt            <= r_ecnt + CW'(1);
                                r_hit             <= 1'b0;
                                r_issue           <= '0;
                                r_state <= (r_ecnt == CNT_LAST) ? ST_FLUSH : ST_SCAN;
                            end else begin
                                r_pend <= 1'b0;
                            end
                        end
                    endcase
                end
                ST_FLUSH: begin
                    r_out_strobe <= 1'b1;
                    r_out_kind   <= mkpd_pkg::EVT_LONG;
                    r_out_key    <= r_pend_key;
                    r_out_held   <= r_pend_held;
                    r_out_last   <= 1'b1;
                    r_pend       <= 1'b0;
                    r_state      <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_result_strobe = r_out_strobe;
    assign o_event_kind    = r_out_kind;
    assign o_event_key     = r_out_key;
    assign o_held_ms       = r_out_held;
    assign o_last_event    = r_out_last;

    `MKPD_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, accept && i_rst_n, busy)
    `MKPD_ASSERT_IMP(a_drop_form, i_clk, i_rst_n,
        o_result_strobe && (o_event_kind == mkpd_pkg::EVT_DROP),
        (o_held_ms == '0) && o_last_event)
    `MKPD_ASSERT_IMP(a_short_last, i_clk, i_rst_n,
        o_result_strobe && (o_event_kind == mkpd_pkg::EVT_SHORT), o_last_event)
    `MKPD_ASSERT_IMP(a_flush_pend, i_clk, i_rst_n, r_state == ST_FLUSH, r_pend)
    `MKPD_ASSERT_IMP(a_wr_idle_read, i_clk, i_rst_n,
        wr_req.time_we || wr_req.key_we, !rd_en && !r_rd_vld)

endmodule

// ===== tb/sv/tb_multi_key_press_duration_classifier.sv =====
// Self-checking testbench for the multi-key press duration classifier.
// Depends on mkpd_pkg and the multi_key_press_duration_classifier top level;
// a scoreboard class predicts the short, long and dropped press events.
`timescale 1ns / 1ps

module tb_multi_key_press_duration_classifier;
    import mkpd_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = (MAX_RESULTS + 1) * (KEY_SLOTS + 2) + 8;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int POOL_SIZE     = 20;

    // Register indexes outside the list; writes to them must be ignored.
    localparam logic [CFG_AW-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] held;
        logic              last;
    } t_key_event;

    class press_scoreboard;
        bit                slot_used[KEY_SLOTS];
        logic [KEY_W-1:0]  slot_key[KEY_SLOTS];
        logic [TIME_W-1:0] slot_time[KEY_SLOTS];
        logic [CFG_W-1:0]  short_min;
        logic [CFG_W-1:0]  long_min;
        t_key_event        expected_q[$];
        int                errors;
        int                n_items;
        int                n_short;
        int                n_long;
        int                n_drop;

        function new();
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            short_min = SHORT_MIN_RST;
            long_min  = LONG_RST;
        endfunction

        function void set_reg(logic [CFG_AW-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_SHORT_MIN: short_min = data;
                CFG_LONG:      long_min = data;
                default: ;
            endcase
        endfunction

        function int find_slot(logic [KEY_W-1:0] key);
            for (int i = 0; i < KEY_SLOTS; i++)
                if (slot_used[i] && slot_key[i] == key) return i;
            return -1;
        endfunction

        function void push_event(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                                 logic [TIME_W-1:0] held, logic last);
            t_key_event ev;
            ev.kind = kind;
            ev.key  = key;
            ev.held = held;
            ev.last = last;
            expected_q.insert(expected_q.size(), ev);
        endfunction

        function void note_input(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                 logic [TIME_W-1:0] now);
            int                s;
            int                best;
            int                n_due;
            int                fired;
            bit                due[KEY_SLOTS];
            logic [TIME_W-1:0] held;
            n_items++;
            case (op) inside
                OP_PRESS: begin
                    s = find_slot(key);
                    if (s < 0) begin
                        for (int i = 0; i < KEY_SLOTS; i++)
                            if (!slot_used[i] && s < 0) s = i;
                        if (s < 0) begin
                            push_event(EVT_DROP, key, '0, 1'b1);
                            n_drop++;
                            return;
                        end
                        slot_used[s] = 1'b1;
                        slot_key[s]  = key;
                    end
                    slot_time[s] = now;
                end
                OP_RELEASE, OP_CANCEL: begin
                    s = find_slot(key);
                    if (s < 0) return;
                    slot_used[s] = 1'b0;
                    held = now - slot_time[s];
                    if (op == OP_RELEASE && held > TIME_W'(short_min)) begin
                        push_event(EVT_SHORT, key, held, 1'b1);
                        n_short++;
                    end
                end
                default: begin
                    n_due = 0;
                    for (int i = 0; i < KEY_SLOTS; i++) begin
                        held   = now - slot_time[i];
                        due[i] = slot_used[i] && held >= TIME_W'(long_min);
                        if (due[i]) n_due++;
                    end
                    fired = (n_due > MAX_RESULTS) ? MAX_RESULTS : n_due;
                    // Fire in ascending key order; the rest wait for a later tick.
                    for (int n = 0; n < fired; n++) begin
                        best = -1;
                        for (int i = 0; i < KEY_SLOTS; i++)
                            if (due[i] && (best < 0 || slot_key[i] < slot_key[best]))
                                best = i;
                        due[best]       = 1'b0;
                        slot_used[best] = 1'b0;
                        push_event(EVT_LONG, slot_key[best], now - slot_time[best],
                                   n == fired - 1);
                        n_long++;
                    end
                end
            endcase
        endfunction

        function void check_result(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                                   logic [TIME_W-1:0] held, logic last);
            t_key_event want;
            if (expected_q.size() == 0) begin
                $error("unexpected result: event_kind %0d event_key %h held_ms %0d",
                       kind, key, held);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (kind !== want.kind) begin
                $error("event_kind: expected %0d, got %0d", want.kind, kind);
                errors++;
            end
            if (key !== want.key) begin
                $error("event_key: expected %h, got %h", want.key, key);
                errors++;
            end
            if (held !== want.held) begin
                $error("held_ms: expected %0d, got %0d", want.held, held);
                errors++;
            end
            if (last !== want.last) begin
                $error("last_event: expected %0d, got %0d", want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [OP_W-1:0]   i_operation;
    logic [KEY_W-1:0]  i_key_code;
    logic [TIME_W-1:0] i_time_ms;
    logic              i_cfg_we;
    logic [CFG_AW-1:0] i_cfg_idx;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              o_result_strobe;
    logic [KIND_W-1:0] o_event_kind;
    logic [KEY_W-1:0]  o_event_key;
    logic [TIME_W-1:0] o_held_ms;
    logic              o_last_event;

    press_scoreboard   sb;
    int                cycle_count = 0;
    int                burst_left = 0;
    int                settings_seen = 1;
    logic [TIME_W-1:0] clock_ms;
    logic [KEY_W-1:0]  key_pool[POOL_SIZE];

    multi_key_press_duration_classifier i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_key_code     (i_key_code),
        .i_time_ms      (i_time_ms),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_result_strobe(o_result_strobe),
        .o_event_kind   (o_event_kind),
        .o_event_key    (o_event_key),
        .o_held_ms      (o_held_ms),
        .o_last_event   (o_last_event)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Check results before noting a new transfer: both can fall on one edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_strobe)
                sb.check_result(o_event_kind, o_event_key, o_held_ms, o_last_event);
            if (start && !busy)
                sb.note_input(i_operation, i_key_code, i_time_ms);
        end
    end

    // Present an item and hold it until the edge that transfers it.
    task automatic send_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                             logic [TIME_W-1:0] stamp);
        start       <= 1'b1;
        i_operation <= op;
        i_key_code  <= key;
        i_time_ms   <= stamp;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic idle(int cycles);
        if (cycles > 0) begin
            start       <= 1'b0;
            i_operation <= OP_W'($urandom);
            i_key_code  <= KEY_W'($urandom);
            i_time_ms   <= $urandom;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Bursts of random length, some long ones with no gaps at all.
    task automatic pace();
        burst_left--;
        if (burst_left <= 0) begin
            idle($urandom_range(0, 6));
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
        end
    endtask

    // Hold off until every expected event is out and the block has gone quiet.
    task automatic settle();
        start <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0 || busy) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_thresholds(logic [CFG_W-1:0] short_min, logic [CFG_W-1:0] long_min);
        settle();
        write_reg(CFG_SHORT_MIN, short_min);
        write_reg(CFG_LONG, long_min);
        settings_seen++;
    endtask

    task automatic random_phase(int items);
        int unsigned      r;
        int unsigned      span;
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        span = ((sb.short_min > sb.long_min) ? sb.short_min : sb.long_min) / 3 + 8;
        clock_ms = $urandom;
        for (int k = 0; k < items; k++) begin
            r  = $urandom_range(0, 99);
            op = (r < 40) ? OP_PRESS : (r < 68) ? OP_RELEASE : (r < 78) ? OP_CANCEL : OP_TICK;
            key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                               : KEY_W'($urandom);
            r = $urandom_range(0, 99);
            if (r < 80)
                clock_ms += $urandom_range(0, span);
            else if (r < 90)
                clock_ms += $urandom_range(span, span * 4);
            else if (r < 95)
                clock_ms -= $urandom_range(0, span);
            else
                clock_ms = $urandom;
            send_item(op, key, clock_ms);
            if ($urandom_range(0, 99) < 2)
                settle();
            else
                pace();
        end
    endtask

    initial begin
        sb = new();
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_operation <= OP_PRESS;
        i_key_code  <= '0;
        i_time_ms   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_SHORT_MIN;
        i_cfg_data  <= '0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom);
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset thresholds (20 ms short, 1000 ms long).
        send_item(OP_PRESS,   16'h0000, 32'd100);
        send_item(OP_PRESS,   16'hFFFF, 32'hFFFF_FFF0);
        send_item(OP_RELEASE, 16'hFFFF, 32'h0000_0010);   // short across the wrap
        send_item(OP_CANCEL,  16'h0000, 32'd120);         // silent removal
        send_item(OP_RELEASE, 16'h0000, 32'd130);         // key no longer held
        pace();
        send_item(OP_PRESS,   16'd5,    32'd200);
        send_item(OP_PRESS,   16'd5,    32'd300);         // refresh
        send_item(OP_RELEASE, 16'd5,    32'd320);         // exactly the minimum
        send_item(OP_PRESS,   16'd9,    32'd5000);
        for (int i = 0; i < KEY_SLOTS - 1; i++) begin
            send_item(OP_PRESS, KEY_W'(16'hFFFF - i * 16'h1111), 32'd1000);
            pace();
        end
        send_item(OP_PRESS,   16'h1234, 32'd1000);        // table full
        send_item(OP_RELEASE, 16'd9,    32'd4000);        // clock went backwards
        send_item(OP_TICK,    '1,       32'd3000);        // every held key fires

        set_thresholds(16'd0, 16'd1);
        random_phase(60);
        set_thresholds(16'hFFFF, 16'hFFFF);
        random_phase(55);
        set_thresholds(CFG_W'($urandom), 16'd0);           // everything expires
        random_phase(50);
        settle();
        write_reg(CFG_SPARE_A, CFG_W'($urandom));
        write_reg(CFG_SPARE_B, CFG_W'($urandom));
        set_thresholds(CFG_W'($urandom_range(0, 200)), CFG_W'($urandom_range(200, 3000)));
        random_phase(70);
        set_thresholds(CFG_W'($urandom), CFG_W'($urandom_range(1, 16'hFFFF)));
        random_phase(60);
        settle();

        $display("Run covered %0d transfers under %0d threshold settings:",
                 sb.n_items, settings_seen);
        $display("  %0d short, %0d long and %0d dropped presses checked.",
                 sb.n_short, sb.n_long, sb.n_drop);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            if (sb.pending() != 0)
                $error("%0d expected events never arrived", sb.pending());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/mkpd_pkg.sv
hdl/mkpd_slot_ram.sv
hdl/multi_key_press_duration_classifier.sv
tb/sv/tb_multi_key_press_duration_classifier.sv
